FILE: src/plle_pkg.sv
// shared types, constants and codes for the pruned landmark label engine
package plle_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES = 512;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int DIST_BITS = 32;
  localparam int DEG_BITS = 10;
  localparam logic [DEG_BITS-1:0] DEG_TOP = 10'd1023;
  localparam logic [DIST_BITS-1:0] INF_DIST = 32'hFFFF_FFFF;
  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  endpoint_a;
    logic [6:0]  endpoint_b;
    logic [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [31:0] path_distance;
    logic        unreachable;
    logic [1:0]  result_kind;
  } res_item_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] x;
    logic [DIST_BITS-1:0] y;
    logic [DIST_BITS-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] sum;
    logic                 lt;
    logic                 le;
  } alu_rsp_t;

endpackage

FILE: src/plle_alu.sv
// shared saturating adder and comparator used by the scans of the sequencer
module plle_alu (
  input  plle_pkg::alu_req_t req,
  output plle_pkg::alu_rsp_t rsp
);
  import plle_pkg::*;

  logic [DIST_BITS:0]   raw;
  logic [DIST_BITS-1:0] sat;

  assign raw = {1'b0, req.x} + {1'b0, req.y};
  assign sat = raw[DIST_BITS] ? INF_DIST : raw[DIST_BITS-1:0];

  assign rsp.sum = sat;
  assign rsp.lt = (sat < req.c);
  assign rsp.le = (sat <= req.c);

endmodule

FILE: src/pruned_landmark_label_engine_unit.sv
// top level: edge store, degree table, label matrix and the build/query sequencer
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_we               cfg_wdata (vertex_count)
//   in       in         in_valid / in_stall  in_data (in_item_t)
//   out      out        out_valid / out_stall out_data (res_item_t)
//
// after reset a clearing pass over all 2**(2*clog2(MAX_VERTICES)) label entries (4096 by default)
// clears the label matrix and the degree table; in_stall stays high meanwhile.
// a load updates the degree of each endpoint in turn; a query reads two labels per landmark column.
// a build clears the label matrix, then per root runs a root scan,
// a tentative table sweep, and per visited vertex a minimum scan, a query and an edge scan.
// all memories have one read and one write port; the label read port sets query speed.
// one request is worked on at a time; a finished result waits in the output register.
module pruned_landmark_label_engine_unit #(
  parameter int MAX_VERTICES = plle_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES = plle_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = plle_pkg::DEF_WEIGHT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  plle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plle_pkg::res_item_t out_data
);
  import plle_pkg::*;

  localparam int VB = $clog2(MAX_VERTICES);
  localparam int VP = 1 << VB;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int LAW = 2 * VB;
  localparam int LD = 1 << LAW;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ED = 1 << EAW;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EDW = 2 * VB + WEIGHT_BITS;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_LDA_RD  = 5'd2;
  localparam logic [4:0] S_LDA_WR  = 5'd3;
  localparam logic [4:0] S_LDB_RD  = 5'd4;
  localparam logic [4:0] S_LDB_WR  = 5'd5;
  localparam logic [4:0] S_Q_RD1   = 5'd6;
  localparam logic [4:0] S_Q_RD2   = 5'd7;
  localparam logic [4:0] S_Q_EX    = 5'd8;
  localparam logic [4:0] S_B_CLR   = 5'd9;
  localparam logic [4:0] S_R_RD    = 5'd10;
  localparam logic [4:0] S_R_EX    = 5'd11;
  localparam logic [4:0] S_R_END   = 5'd12;
  localparam logic [4:0] S_P_INIT  = 5'd13;
  localparam logic [4:0] S_P_ROOT  = 5'd14;
  localparam logic [4:0] S_M_RD    = 5'd15;
  localparam logic [4:0] S_M_EX    = 5'd16;
  localparam logic [4:0] S_M_END   = 5'd17;
  localparam logic [4:0] S_P_PRUNE = 5'd18;
  localparam logic [4:0] S_E_RD    = 5'd19;
  localparam logic [4:0] S_E_EX    = 5'd20;
  localparam logic [4:0] S_E_RD2   = 5'd21;
  localparam logic [4:0] S_E_REL   = 5'd22;
  localparam logic [4:0] S_DONE    = 5'd23;

  // memories
  logic [DIST_BITS:0]   lbl_mem [LD];
  logic [DEG_BITS-1:0]  deg_mem [VP];
  logic                 taken_mem [VP];
  logic [DIST_BITS:0]   tent_mem [VP];
  logic [EDW-1:0]       edge_mem [ED];

  logic [DIST_BITS:0]   lbl_q, lbl_wdata;
  logic [LAW-1:0]       lbl_raddr, lbl_waddr;
  logic                 lbl_we;
  logic [DEG_BITS-1:0]  deg_q, deg_wdata;
  logic [VB-1:0]        deg_raddr, deg_waddr;
  logic                 deg_we;
  logic                 taken_q, taken_wdata, taken_we;
  logic [VB-1:0]        taken_waddr;
  logic [DIST_BITS:0]   tent_q, tent_wdata;
  logic [VB-1:0]        tent_raddr, tent_waddr;
  logic                 tent_we;
  logic [EDW-1:0]       edge_q, edge_wdata;
  logic                 edge_we;

  // control and working registers
  logic [4:0]           state;
  logic [6:0]           vcount;
  logic [LAW-1:0]       clr;
  logic [EW-1:0]        etotal;
  logic [EAW-1:0]       ecnt;
  logic [VB-1:0]        vcnt, va, vb, qs, qt, k, u, pick, other;
  logic [WEIGHT_BITS-1:0] wgt;
  logic                 qret, found, any;
  logic [DIST_BITS-1:0] qbest, best, tent_u;
  logic [DIST_BITS:0]   l1;
  logic [DEG_BITS-1:0]  degpick;
  res_item_t            res;

  logic [NW-1:0]        n;
  logic [VB-1:0]        nlast;
  logic [EAW-1:0]       elast;
  logic                 a_ok, b_ok, accept;
  logic [VB-1:0]        in_va, in_vb;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic                 q_take, q_found_new, prune;
  logic [DIST_BITS-1:0] q_best_new;
  logic [VB-1:0]        e_a, e_b;
  logic [WEIGHT_BITS-1:0] e_w;
  logic                 e_hit;
  logic [VB-1:0]        e_other;

  plle_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // effective vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (vcount == 7'd0) begin
      n = NW'(1);
    end else if (32'(vcount) > 32'(MAX_VERTICES)) begin
      n = NW'(MAX_VERTICES);
    end else begin
      n = NW'(vcount);
    end
  end

  assign nlast = VB'(n - NW'(1));
  assign elast = EAW'(etotal - EW'(1));

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign a_ok = (in_data.endpoint_a != 7'd0) && (32'(in_data.endpoint_a) <= 32'(n));
  assign b_ok = (in_data.endpoint_b != 7'd0) && (32'(in_data.endpoint_b) <= 32'(n));
  assign in_va = VB'(32'(in_data.endpoint_a) - 32'd1);
  assign in_vb = VB'(32'(in_data.endpoint_b) - 32'd1);

  assign e_a = edge_q[EDW-1 -: VB];
  assign e_b = edge_q[EDW-VB-1 -: VB];
  assign e_w = edge_q[WEIGHT_BITS-1:0];

  always_comb begin
    e_hit = 1'b0;
    e_other = e_a;
    if ((32'(e_a) < 32'(n)) && (32'(e_b) < 32'(n))) begin
      if (e_a == u) begin
        e_hit = 1'b1;
        e_other = e_b;
      end else if (e_b == u) begin
        e_hit = 1'b1;
        e_other = e_a;
      end
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_Q_EX: begin
        alu_req.x = l1[DIST_BITS-1:0];
        alu_req.y = lbl_q[DIST_BITS-1:0];
        alu_req.c = qbest;
      end
      S_R_EX: begin
        alu_req.x = DIST_BITS'(degpick);
        alu_req.c = DIST_BITS'(deg_q);
      end
      S_M_EX: begin
        alu_req.x = tent_q[DIST_BITS-1:0];
        alu_req.c = best;
      end
      S_P_PRUNE: begin
        alu_req.x = qbest;
        alu_req.c = tent_u;
      end
      S_E_REL: begin
        alu_req.x = tent_u;
        alu_req.y = DIST_BITS'(e_w);
        alu_req.c = tent_q[DIST_BITS-1:0];
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  assign q_take = l1[DIST_BITS] && lbl_q[DIST_BITS] && (!found || alu_rsp.lt);
  assign q_found_new = found || q_take;
  assign q_best_new = q_take ? alu_rsp.sum : qbest;
  assign prune = found && alu_rsp.le;

  // memory port control
  always_comb begin
    lbl_raddr = {qs, vcnt};
    lbl_we = 1'b0;
    lbl_waddr = clr;
    lbl_wdata = '0;
    deg_raddr = vcnt;
    deg_we = 1'b0;
    deg_waddr = clr[VB-1:0];
    deg_wdata = '0;
    taken_we = 1'b0;
    taken_waddr = clr[VB-1:0];
    taken_wdata = 1'b0;
    tent_raddr = vcnt;
    tent_we = 1'b0;
    tent_waddr = vcnt;
    tent_wdata = {1'b0, INF_DIST};
    edge_we = 1'b0;
    edge_wdata = {va, vb, wgt};
    unique case (state)
      S_INIT: begin
        lbl_we = 1'b1;
        deg_we = 1'b1;
        taken_we = 1'b1;
      end
      S_B_CLR: begin
        lbl_we = 1'b1;
        taken_we = 1'b1;
      end
      S_LDA_RD: begin
        edge_we = 1'b1;
        deg_raddr = va;
      end
      S_LDA_WR: begin
        deg_we = 1'b1;
        deg_waddr = va;
        deg_wdata = (deg_q == DEG_TOP) ? deg_q : deg_q + DEG_BITS'(1);
      end
      S_LDB_RD: begin
        deg_raddr = vb;
      end
      S_LDB_WR: begin
        deg_we = 1'b1;
        deg_waddr = vb;
        deg_wdata = (deg_q == DEG_TOP) ? deg_q : deg_q + DEG_BITS'(1);
      end
      S_Q_RD2: begin
        lbl_raddr = {qt, vcnt};
      end
      S_R_END: begin
        taken_we = any;
        taken_waddr = pick;
        taken_wdata = 1'b1;
      end
      S_P_INIT: begin
        tent_we = 1'b1;
      end
      S_P_ROOT: begin
        tent_we = 1'b1;
        tent_waddr = k;
        tent_wdata = {1'b1, DIST_BITS'(0)};
      end
      S_M_END: begin
        tent_we = any;
        tent_waddr = u;
        tent_wdata = {1'b0, best};
      end
      S_P_PRUNE: begin
        lbl_we = !prune;
        lbl_waddr = {u, k};
        lbl_wdata = {1'b1, tent_u};
      end
      S_E_RD2: begin
        tent_raddr = other;
      end
      S_E_REL: begin
        tent_we = alu_rsp.lt;
        tent_waddr = other;
        tent_wdata = {1'b1, alu_rsp.sum};
      end
      default: begin
        lbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    lbl_q <= lbl_mem[lbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q <= deg_mem[deg_raddr];
  end

  always_ff @(posedge clk) begin
    if (taken_we) begin
      taken_mem[taken_waddr] <= taken_wdata;
    end
    taken_q <= taken_mem[vcnt];
  end

  always_ff @(posedge clk) begin
    if (tent_we) begin
      tent_mem[tent_waddr] <= tent_wdata;
    end
    tent_q <= tent_mem[tent_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[etotal[EAW-1:0]] <= edge_wdata;
    end
    edge_q <= edge_mem[ecnt];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      vcount <= VCOUNT_RESET;
      clr <= '0;
      etotal <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_wdata;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clr <= clr + LAW'(1);
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            va <= in_va;
            vb <= in_vb;
            wgt <= WEIGHT_BITS'(32'(in_data.edge_weight));
            unique case (in_data.operation)
              OP_LOAD: begin
                if (a_ok && b_ok) begin
                  if (32'(etotal) >= 32'(MAX_EDGES)) begin
                    res <= '{path_distance: '0, unreachable: 1'b0,
                             result_kind: KIND_OVERFLOW};
                    state <= S_DONE;
                  end else begin
                    state <= S_LDA_RD;
                  end
                end
              end
              OP_BUILD: begin
                clr <= '0;
                state <= S_B_CLR;
              end
              OP_QUERY: begin
                if (a_ok && b_ok) begin
                  qs <= in_va;
                  qt <= in_vb;
                  qret <= 1'b0;
                  found <= 1'b0;
                  qbest <= INF_DIST;
                  vcnt <= '0;
                  state <= S_Q_RD1;
                end else begin
                  res <= '{path_distance: INF_DIST, unreachable: 1'b1,
                           result_kind: KIND_QUERY};
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_LDA_RD: begin
          etotal <= etotal + EW'(1);
          state <= S_LDA_WR;
        end
        S_LDA_WR: state <= S_LDB_RD;
        S_LDB_RD: state <= S_LDB_WR;
        S_LDB_WR: state <= S_IDLE;
        S_Q_RD1: state <= S_Q_RD2;
        S_Q_RD2: begin
          l1 <= lbl_q;
          state <= S_Q_EX;
        end
        S_Q_EX: begin
          found <= q_found_new;
          qbest <= q_best_new;
          if (vcnt == nlast) begin
            if (qret) begin
              state <= S_P_PRUNE;
            end else begin
              res <= '{path_distance: q_found_new ? q_best_new : INF_DIST,
                       unreachable: !q_found_new, result_kind: KIND_QUERY};
              state <= S_DONE;
            end
          end else begin
            vcnt <= vcnt + VB'(1);
            state <= S_Q_RD1;
          end
        end
        S_B_CLR: begin
          clr <= clr + LAW'(1);
          if (clr == '1) begin
            vcnt <= nlast;
            any <= 1'b0;
            state <= S_R_RD;
          end
        end
        S_R_RD: state <= S_R_EX;
        S_R_EX: begin
          // descending scan, so a strict compare keeps the higher vertex on ties
          if (!taken_q && (deg_q != '0) && (!any || alu_rsp.lt)) begin
            pick <= vcnt;
            degpick <= deg_q;
            any <= 1'b1;
          end
          if (vcnt == '0) begin
            state <= S_R_END;
          end else begin
            vcnt <= vcnt - VB'(1);
            state <= S_R_RD;
          end
        end
        S_R_END: begin
          if (!any) begin
            res <= '{path_distance: '0, unreachable: 1'b0, result_kind: KIND_BUILD};
            state <= S_DONE;
          end else begin
            k <= pick;
            vcnt <= '0;
            state <= S_P_INIT;
          end
        end
        S_P_INIT: begin
          vcnt <= vcnt + VB'(1);
          if (vcnt == '1) begin
            state <= S_P_ROOT;
          end
        end
        S_P_ROOT: begin
          vcnt <= '0;
          any <= 1'b0;
          state <= S_M_RD;
        end
        S_M_RD: state <= S_M_EX;
        S_M_EX: begin
          // ascending scan, so the lowest vertex wins a tie
          if (tent_q[DIST_BITS] && (!any || alu_rsp.lt)) begin
            u <= vcnt;
            best <= tent_q[DIST_BITS-1:0];
            any <= 1'b1;
          end
          if (vcnt == nlast) begin
            state <= S_M_END;
          end else begin
            vcnt <= vcnt + VB'(1);
            state <= S_M_RD;
          end
        end
        S_M_END: begin
          if (!any) begin
            vcnt <= nlast;
            state <= S_R_RD;
          end else begin
            tent_u <= best;
            qs <= k;
            qt <= u;
            qret <= 1'b1;
            found <= 1'b0;
            qbest <= INF_DIST;
            vcnt <= '0;
            state <= S_Q_RD1;
          end
        end
        S_P_PRUNE: begin
          if (prune || (etotal == '0)) begin
            vcnt <= '0;
            any <= 1'b0;
            state <= S_M_RD;
          end else begin
            ecnt <= '0;
            state <= S_E_RD;
          end
        end
        S_E_RD: state <= S_E_EX;
        S_E_EX: begin
          if (e_hit) begin
            other <= e_other;
            state <= S_E_RD2;
          end else if (ecnt == elast) begin
            vcnt <= '0;
            any <= 1'b0;
            state <= S_M_RD;
          end else begin
            ecnt <= ecnt + EAW'(1);
            state <= S_E_RD;
          end
        end
        S_E_RD2: state <= S_E_REL;
        S_E_REL: begin
          if (ecnt == elast) begin
            vcnt <= '0;
            any <= 1'b0;
            state <= S_M_RD;
          end else begin
            ecnt <= ecnt + EAW'(1);
            state <= S_E_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
